### hw/rtl/lfu_pkg.sv
// Package for the LFU key-value cache: field widths, codes and the stored row type.
// Used by the interfaces, the row memory, the scan unit and the top level.
package lfu_pkg;

  localparam int LFU_ENTRIES = 16;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int USES_W  = 32;
  localparam int STAMP_W = 48;
  localparam int CAP_W   = 5;
  localparam int APB_W   = 32;
  localparam int ADDR_W  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [USES_W-1:0]  uses;
    logic [STAMP_W-1:0] stamp;
  } row_t;

  typedef struct packed {
    logic hit;
    logic vic;
    logic free;
  } scan_flags_t;

endpackage

### hw/rtl/lfu_req_if.sv
// Request channel of the LFU cache: valid/ready handshake with cmd, key and data_in.
// Depends on lfu_pkg for field widths.
interface lfu_req_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic signed [lfu_pkg::KEY_W-1:0]  key;
  logic signed [lfu_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output cmd, output key, output data_in, input ready);
  modport sink   (input valid, input cmd, input key, input data_in, output ready);
endinterface

### hw/rtl/lfu_rsp_if.sv
// Response channel of the LFU cache: valid/ready handshake with found and data_out.
// Depends on lfu_pkg for field widths.
interface lfu_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic signed [lfu_pkg::DATA_W-1:0] data_out;

  modport source (output valid, output found, output data_out, input ready);
  modport sink   (input valid, input found, input data_out, output ready);
endinterface

### hw/rtl/lfu_mem.sv
// Row memory of the LFU cache: one write port, one read port with registered data.
// Depends on lfu_pkg for the row type.
module lfu_mem #(
  parameter int ENTRIES = lfu_pkg::LFU_ENTRIES
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] waddr,
  input  lfu_pkg::row_t                            wdata,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] raddr,
  output lfu_pkg::row_t                            rdata
);

  lfu_pkg::row_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lfu_scan.sv
// Scan unit of the LFU cache: takes one row per cycle while en is high and keeps the key match,
// the least-used victim, the lowest free slot and the occupancy. Depends on lfu_pkg.
module lfu_scan #(
  parameter int ENTRIES = lfu_pkg::LFU_ENTRIES,
  localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        en,
  input  logic [IDX_W-1:0]            idx,
  input  lfu_pkg::row_t               row,
  input  logic [lfu_pkg::KEY_W-1:0]   key,
  output lfu_pkg::scan_flags_t        flags,
  output logic [IDX_W-1:0]            hit_idx,
  output lfu_pkg::row_t               hit_row,
  output logic [IDX_W-1:0]            vic_idx,
  output logic [IDX_W-1:0]            free_idx,
  output logic [CNT_W-1:0]            used
);

  logic [lfu_pkg::USES_W-1:0]  vic_uses;
  logic [lfu_pkg::STAMP_W-1:0] vic_stamp;
  logic take_hit;
  logic take_vic;
  logic take_free;

  always_comb begin
    take_hit  = en && row.valid && !flags.hit && (row.key == key);
    take_vic  = en && row.valid &&
                (!flags.vic || (row.uses < vic_uses) ||
                 ((row.uses == vic_uses) && (row.stamp < vic_stamp)));
    take_free = en && !row.valid && !flags.free;
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
      used  <= '0;
    end else begin
      if (en && row.valid) begin
        used <= used + CNT_W'(1);
      end
      if (take_hit) begin
        flags.hit <= 1'b1;
      end
      if (take_vic) begin
        flags.vic <= 1'b1;
      end
      if (take_free) begin
        flags.free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx <= idx;
      hit_row <= row;
    end
    if (take_vic) begin
      vic_idx   <= idx;
      vic_uses  <= row.uses;
      vic_stamp <= row.stamp;
    end
    if (take_free) begin
      free_idx <= idx;
    end
  end

endmodule

### hw/rtl/lfu_cache_key_value_store.sv
// Top level of the LFU key-value cache with oldest-stamp tie break.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_mem and lfu_scan.
//
//   channel  | modport | transfer when          | payload
//   ---------+---------+------------------------+----------------------
//   req      | sink    | req.valid && req.ready | cmd, key, data_in
//   rsp      | source  | rsp.valid && rsp.ready | found, data_out
//   apb      | slave   | psel&&penable&&pwrite  | paddr, pwdata (capacity)
//
// An item passes through the scan, wait and decide steps, plus an evict step for an insert
// that also evicts: the scan unit reads one row per cycle from the single-port-read row
// memory. With capacity zero an item goes from idle straight to the decide step and
// writes no row. After reset a clearing pass writes every row invalid, with req not ready.
// req is ready only while idle; a result waits in the output register while the next
// item is taken, and the final step holds while that register is still full.
module lfu_cache_key_value_store #(
  parameter int ENTRIES = lfu_pkg::LFU_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  lfu_req_if.sink                     req,
  lfu_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0]  paddr,
  input  logic [lfu_pkg::APB_W-1:0]   pwdata,
  output logic [lfu_pkg::APB_W-1:0]   prdata,
  output logic                        pready
);

  localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = CNT_W > lfu_pkg::CAP_W ? CNT_W : lfu_pkg::CAP_W;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_WAIT   = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_EVICT  = 6'b100000
  } state_t;

  state_t state;
  logic [IDX_W-1:0]                 addr;
  logic [lfu_pkg::CAP_W-1:0]        capacity;
  logic [lfu_pkg::STAMP_W-1:0]      clock_stamp;
  logic                             cmd_q;
  logic [lfu_pkg::KEY_W-1:0]        key_q;
  logic [lfu_pkg::DATA_W-1:0]       din_q;
  logic                             rsp_valid;
  logic                             rsp_found;
  logic [lfu_pkg::DATA_W-1:0]       rsp_data;
  logic                             scan_vld;
  logic [IDX_W-1:0]                 scan_idx;

  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_waddr;
  lfu_pkg::row_t                    mem_wdata;
  lfu_pkg::row_t                    mem_rdata;

  lfu_pkg::scan_flags_t             flags;
  logic [IDX_W-1:0]                 hit_idx;
  lfu_pkg::row_t                    hit_row;
  logic [IDX_W-1:0]                 vic_idx;
  logic [IDX_W-1:0]                 free_idx;
  logic [CNT_W-1:0]                 used;

  logic                             accept;
  logic                             cfg_write;
  logic                             cap_zero;
  logic                             out_free;
  logic                             evict;
  logic [IDX_W-1:0]                 ins_slot;
  logic                             evict_extra;
  logic [lfu_pkg::USES_W-1:0]       uses_inc;
  logic                             res_found;
  logic [lfu_pkg::DATA_W-1:0]       res_data;
  logic                             last;

  assign accept    = req.valid && req.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cap_zero  = (capacity == '0);
  assign out_free  = !rsp_valid || rsp.ready;
  assign last      = (addr == IDX_W'(ENTRIES - 1));
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == lfu_pkg::REG_CAPACITY) ?
                     lfu_pkg::APB_W'(capacity) : '0;

  assign req.ready    = (state == ST_IDLE);
  assign rsp.valid    = rsp_valid;
  assign rsp.found    = rsp_found;
  assign rsp.data_out = rsp_data;

  lfu_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  lfu_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .en       (scan_vld),
    .idx      (scan_idx),
    .row      (mem_rdata),
    .key      (key_q),
    .flags    (flags),
    .hit_idx  (hit_idx),
    .hit_row  (hit_row),
    .vic_idx  (vic_idx),
    .free_idx (free_idx),
    .used     (used)
  );

  always_comb begin
    evict = (CMP_W'(used) >= CMP_W'(capacity)) || (used == CNT_W'(ENTRIES));
    if (flags.free && (!evict || (free_idx < vic_idx))) begin
      ins_slot = free_idx;
    end else begin
      ins_slot = vic_idx;
    end
    evict_extra = (cmd_q == lfu_pkg::CMD_PUT) && !flags.hit && evict &&
                  (ins_slot != vic_idx);
    uses_inc = (hit_row.uses == '1) ? hit_row.uses : hit_row.uses + lfu_pkg::USES_W'(1);

    if (cap_zero) begin
      res_found = 1'b0;
      res_data  = (cmd_q == lfu_pkg::CMD_PUT) ? '0 : '1;
    end else if (cmd_q == lfu_pkg::CMD_PUT) begin
      res_found = flags.hit;
      res_data  = '0;
    end else begin
      res_found = flags.hit;
      res_data  = flags.hit ? hit_row.data : '1;
    end

    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_DECIDE: begin
        if (out_free && !cap_zero) begin
          if (flags.hit) begin
            mem_we          = 1'b1;
            mem_waddr       = hit_idx;
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = key_q;
            mem_wdata.data  = (cmd_q == lfu_pkg::CMD_PUT) ? din_q : hit_row.data;
            mem_wdata.uses  = uses_inc;
            mem_wdata.stamp = clock_stamp;
          end else if (cmd_q == lfu_pkg::CMD_PUT) begin
            mem_we          = 1'b1;
            mem_waddr       = ins_slot;
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = key_q;
            mem_wdata.data  = din_q;
            mem_wdata.uses  = lfu_pkg::USES_W'(1);
            mem_wdata.stamp = clock_stamp;
          end
        end
      end
      ST_EVICT: begin
        mem_we    = 1'b1;
        mem_waddr = vic_idx;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      addr        <= '0;
      capacity    <= lfu_pkg::CAP_RESET;
      clock_stamp <= '0;
      rsp_valid   <= 1'b0;
      scan_vld    <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == lfu_pkg::REG_CAPACITY)) begin
        capacity <= pwdata[lfu_pkg::CAP_W-1:0];
      end
      scan_vld <= (state == ST_SCAN);
      if ((state == ST_DECIDE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (last) begin
            addr  <= '0;
            state <= ST_IDLE;
          end else begin
            addr <= addr + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            addr <= '0;
            if (cap_zero) begin
              state <= ST_DECIDE;
            end else begin
              clock_stamp <= clock_stamp + lfu_pkg::STAMP_W'(1);
              state       <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (last) begin
            addr  <= '0;
            state <= ST_WAIT;
          end else begin
            addr <= addr + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            state <= (!cap_zero && evict_extra) ? ST_EVICT : ST_IDLE;
          end
        end
        ST_EVICT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= addr;
    if (accept) begin
      cmd_q <= req.cmd;
      key_q <= req.key;
      din_q <= req.data_in;
    end
    if ((state == ST_DECIDE) && out_free) begin
      rsp_found <= res_found;
      rsp_data  <= res_data;
    end
  end

`ifndef SYNTHESIS
  a_rsp_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DECIDE))
    else $error("response raised outside the decide step");

  a_victim_present: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) && !cap_zero && (cmd_q == lfu_pkg::CMD_PUT) &&
    !flags.hit && evict |-> flags.vic)
    else $error("eviction needed but no victim found");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) || (state == ST_WAIT) |-> !mem_we)
    else $error("row memory written during scan");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |-> (used <= CNT_W'(ENTRIES)))
    else $error("occupancy above entry count");
`endif

endmodule
